FILE: hw/rtl/hutv_pkg.sv
`default_nettype none

package hutv_pkg;

    localparam int AXES          = 4;
    localparam int HASH_BYTES    = 16;
    localparam int OUT_FRAC_BITS = 15;
    localparam int COEF_FRAC_BITS = 15;

    // widths that hold every value at the fixed coefficient scale
    localparam int PROD_W = 25;
    localparam int HALF_W = 28;
    localparam int SUM_W  = 29;
    localparam int MAG_W  = 28;
    localparam int SQ_W   = 2 * MAG_W;
    localparam int N2_W   = SQ_W + 2;
    localparam int ROOT_W = N2_W / 2;
    localparam int SREM_W = ROOT_W + 1;
    localparam int NUM_W  = MAG_W + OUT_FRAC_BITS + 1;
    localparam int Q_W    = OUT_FRAC_BITS + 2;
    localparam int DREM_W = ROOT_W;
    localparam int OUT_W  = 16;

    localparam logic signed [SUM_W-1:0] BASE_TERM = SUM_W'(255 * (1 << COEF_FRAC_BITS));
    localparam logic signed [OUT_W-1:0] OUT_MAX   = 16'sh7fff;
    localparam logic signed [OUT_W-1:0] OUT_MIN   = 16'sh8000;

    localparam logic signed [15:0] COEF_TAB [0:AXES-1][0:HASH_BYTES-1] = '{
        '{ 21852, 32567, 26684, 7202, -15951, -30974, -30212, -14052,
           9270, 27867, 32262, 20214, -2136, -23397, -32734, -25388 },
        '{ 12784, -22792, -30569, -1061, 29741, 24268, -10805, -32699,
           -14711, 21220, 31269, 3179, -28789, -25643, 8779, 32493 },
        '{ 30901, -20564, -17216, 32021, -4093, -29297, 23589, 13599,
           -32639, 8121, 27235, -26245, -9769, 32746, -12022, -24746 },
        '{ -24383, 3519, 19145, -32012, 28496, -10396, -13024, 29779,
           -31293, 16793, 6302, -26172, 32647, -22414, 711, 21357 }
    };

    // sideband that travels with an item through the root stages
    typedef struct packed {
        logic                       valid;
        logic                       zero;
        logic [AXES-1:0]            neg;
        logic [AXES-1:0][MAG_W-1:0] mag;
    } side_t;

    // sideband that travels with an item through the divide stages
    typedef struct packed {
        logic            valid;
        logic            zero;
        logic [AXES-1:0] neg;
    } dctl_t;

endpackage

`default_nettype wire

FILE: hw/rtl/hutv_isqrt.sv
`default_nettype none

module hutv_isqrt (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic [hutv_pkg::N2_W-1:0] n2,
    input  wire hutv_pkg::side_t           side_in,
    output logic [hutv_pkg::ROOT_W-1:0]    root,
    output hutv_pkg::side_t                side_out
);
    import hutv_pkg::*;

    logic [SREM_W-1:0] rem_reg  [ROOT_W];
    logic [ROOT_W-1:0] root_reg [ROOT_W];
    logic [N2_W-1:0]   n_reg    [ROOT_W];
    side_t             side_reg [ROOT_W];

    logic [SREM_W-1:0] rem_next  [ROOT_W];
    logic [ROOT_W-1:0] root_next [ROOT_W];
    logic [N2_W-1:0]   n_next    [ROOT_W];

    // one root bit per stage, two radicand bits consumed
    always_comb
    begin
        logic [SREM_W-1:0] rp;
        logic [ROOT_W-1:0] qp;
        logic [N2_W-1:0]   np;
        logic [SREM_W+1:0] cur;
        logic [SREM_W+1:0] trial;
        for (int s = 0; s < ROOT_W; s++)
        begin
            if (s == 0)
            begin
                rp = '0;
                qp = '0;
                np = n2;
            end
            else
            begin
                rp = rem_reg[s-1];
                qp = root_reg[s-1];
                np = n_reg[s-1];
            end
            cur   = {rp, np[N2_W-1 -: 2]};
            trial = {1'b0, qp, 2'b01};
            if (cur >= trial)
            begin
                rem_next[s]  = SREM_W'(cur - trial);
                root_next[s] = {qp[ROOT_W-2:0], 1'b1};
            end
            else
            begin
                rem_next[s]  = SREM_W'(cur);
                root_next[s] = {qp[ROOT_W-2:0], 1'b0};
            end
            n_next[s] = {np[N2_W-3:0], 2'b00};
        end
    end

    // stage registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < ROOT_W; s++)
            begin
                side_reg[s] <= '0;
            end
        end
        else
        begin
            for (int s = 0; s < ROOT_W; s++)
            begin
                side_reg[s] <= (s == 0) ? side_in : side_reg[s-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int s = 0; s < ROOT_W; s++)
        begin
            rem_reg[s]  <= rem_next[s];
            root_reg[s] <= root_next[s];
            n_reg[s]    <= n_next[s];
        end
    end

    assign root     = root_reg[ROOT_W-1];
    assign side_out = side_reg[ROOT_W-1];

endmodule

`default_nettype wire

FILE: hw/rtl/hutv_div.sv
`default_nettype none

module hutv_div (
    input  wire logic                                             clk,
    input  wire logic                                             rst_n,
    input  wire logic [hutv_pkg::AXES-1:0][hutv_pkg::NUM_W-1:0]   num,
    input  wire logic [hutv_pkg::ROOT_W-1:0]                      den,
    input  wire hutv_pkg::dctl_t                                  ctl_in,
    output logic [hutv_pkg::AXES-1:0][hutv_pkg::Q_W-1:0]          quo,
    output hutv_pkg::dctl_t                                       ctl_out
);
    import hutv_pkg::*;

    logic [AXES-1:0][DREM_W-1:0] rem_reg [Q_W];
    logic [AXES-1:0][Q_W-1:0]    low_reg [Q_W];
    logic [AXES-1:0][Q_W-1:0]    quo_reg [Q_W];
    logic [ROOT_W-1:0]           den_reg [Q_W];
    dctl_t                       ctl_reg [Q_W];

    logic [AXES-1:0][DREM_W-1:0] rem_next [Q_W];
    logic [AXES-1:0][Q_W-1:0]    low_next [Q_W];
    logic [AXES-1:0][Q_W-1:0]    quo_next [Q_W];

    // restoring division, one quotient bit per stage for each lane
    always_comb
    begin
        logic [DREM_W-1:0] rp;
        logic [Q_W-1:0]    lp;
        logic [Q_W-1:0]    qp;
        logic [ROOT_W-1:0] dp;
        logic [DREM_W:0]   cur;
        for (int s = 0; s < Q_W; s++)
        begin
            for (int a = 0; a < AXES; a++)
            begin
                if (s == 0)
                begin
                    rp = DREM_W'(num[a][NUM_W-1:Q_W]);
                    lp = num[a][Q_W-1:0];
                    qp = '0;
                    dp = den;
                end
                else
                begin
                    rp = rem_reg[s-1][a];
                    lp = low_reg[s-1][a];
                    qp = quo_reg[s-1][a];
                    dp = den_reg[s-1];
                end
                cur = {rp, lp[Q_W-1]};
                if (cur >= {1'b0, dp})
                begin
                    rem_next[s][a] = DREM_W'(cur - {1'b0, dp});
                    quo_next[s][a] = {qp[Q_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next[s][a] = DREM_W'(cur);
                    quo_next[s][a] = {qp[Q_W-2:0], 1'b0};
                end
                low_next[s][a] = {lp[Q_W-2:0], 1'b0};
            end
        end
    end

    // control travels alongside
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < Q_W; s++)
            begin
                ctl_reg[s] <= '0;
            end
        end
        else
        begin
            for (int s = 0; s < Q_W; s++)
            begin
                ctl_reg[s] <= (s == 0) ? ctl_in : ctl_reg[s-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int s = 0; s < Q_W; s++)
        begin
            rem_reg[s] <= rem_next[s];
            low_reg[s] <= low_next[s];
            quo_reg[s] <= quo_next[s];
            den_reg[s] <= (s == 0) ? den : den_reg[s-1];
        end
    end

    assign quo     = quo_reg[Q_W-1];
    assign ctl_out = ctl_reg[Q_W-1];

endmodule

`default_nettype wire

FILE: hw/rtl/hash_to_unit_vector4.sv
`default_nettype none
// channel   | ports                              | handshake
// ----------+------------------------------------+----------------------------
// request   | hash_low, hash_high                | start && !busy
// result    | comp_x, comp_y, comp_z, comp_w     | done, one cycle, no stall
//
// one request per cycle; busy stays low because nothing in the pipe can stall
// stages: 5 sum and square stages, 29 root stages (one bit each),
// one numerator stage, 17 divide stages (one quotient bit each), one output
// reset clears the valid bits and the root and divide sideband registers; other data registers are left as they are
// the receiver cannot hold results off, so each result shows for one cycle

module hash_to_unit_vector4 (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [63:0] hash_low,
    input  wire logic [63:0] hash_high,
    output logic             done,
    output logic signed [15:0] comp_x,
    output logic signed [15:0] comp_y,
    output logic signed [15:0] comp_z,
    output logic signed [15:0] comp_w
);
    import hutv_pkg::*;

    logic accept;
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, prep_v_reg, done_reg;

    logic signed [HALF_W-1:0] half_next [AXES][2];
    logic signed [HALF_W-1:0] half_reg  [AXES][2];
    logic signed [SUM_W-1:0]  sum_reg   [AXES];
    logic [AXES-1:0][MAG_W-1:0] mag3_reg, mag4_reg, mag5_reg;
    logic [AXES-1:0]          neg3_reg, neg4_reg, neg5_reg;
    logic [SQ_W-1:0]          sq_reg    [AXES];
    logic [N2_W-1:0]          n2_reg;
    logic                     zero5_reg;

    side_t                    side_in, side_out;
    logic [ROOT_W-1:0]        root;

    logic [AXES-1:0][NUM_W-1:0] num_reg;
    logic [ROOT_W-1:0]        den_reg;
    logic                     dzero_reg;
    logic [AXES-1:0]          dneg_reg;
    dctl_t                    dctl_in, dctl_out;
    logic [AXES-1:0][Q_W-1:0] quo;

    logic signed [OUT_W-1:0]  comp_reg [AXES];

    assign busy   = 1'b0;
    assign accept = start && !busy;

    // byte times coefficient, eight terms per half hash
    always_comb
    begin
        logic [7:0]               b;
        logic signed [PROD_W-1:0] p;
        for (int a = 0; a < AXES; a++)
        begin
            for (int h = 0; h < 2; h++)
            begin
                half_next[a][h] = '0;
                for (int j = 0; j < 8; j++)
                begin
                    b = (h == 0) ? hash_low[8*j +: 8] : hash_high[8*j +: 8];
                    p = $signed({1'b0, b}) * COEF_TAB[a][8*h + j];
                    half_next[a][h] = half_next[a][h] + HALF_W'(p);
                end
            end
        end
    end

    // valid chain
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg     <= 1'b0;
            v2_reg     <= 1'b0;
            v3_reg     <= 1'b0;
            v4_reg     <= 1'b0;
            v5_reg     <= 1'b0;
            prep_v_reg <= 1'b0;
            done_reg   <= 1'b0;
        end
        else
        begin
            v1_reg     <= accept;
            v2_reg     <= v1_reg;
            v3_reg     <= v2_reg;
            v4_reg     <= v3_reg;
            v5_reg     <= v4_reg;
            prep_v_reg <= side_out.valid;
            done_reg   <= dctl_out.valid;
        end
    end

    // sums, magnitudes, squares and norm squared
    always_ff @(posedge clk)
    begin
        for (int a = 0; a < AXES; a++)
        begin
            half_reg[a][0] <= half_next[a][0];
            half_reg[a][1] <= half_next[a][1];
            sum_reg[a]     <= BASE_TERM + SUM_W'(half_reg[a][0]) + SUM_W'(half_reg[a][1]);
            neg3_reg[a]    <= sum_reg[a][SUM_W-1];
            mag3_reg[a]    <= sum_reg[a][SUM_W-1] ? MAG_W'(-sum_reg[a]) : MAG_W'(sum_reg[a]);
            sq_reg[a]      <= mag3_reg[a] * mag3_reg[a];
        end
        mag4_reg  <= mag3_reg;
        neg4_reg  <= neg3_reg;
        mag5_reg  <= mag4_reg;
        neg5_reg  <= neg4_reg;
        zero5_reg <= (mag4_reg == '0);
        n2_reg    <= N2_W'(sq_reg[0]) + N2_W'(sq_reg[1]) + N2_W'(sq_reg[2])
                   + N2_W'(sq_reg[3]);
    end

    assign side_in.valid = v5_reg;
    assign side_in.zero  = zero5_reg;
    assign side_in.neg   = neg5_reg;
    assign side_in.mag   = mag5_reg;

    hutv_isqrt u_isqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .n2       (n2_reg),
        .side_in  (side_in),
        .root     (root),
        .side_out (side_out)
    );

    // rounded numerator and a divisor that is never zero
    always_ff @(posedge clk)
    begin
        for (int a = 0; a < AXES; a++)
        begin
            num_reg[a] <= {1'b0, side_out.mag[a], OUT_FRAC_BITS'(0)}
                        + NUM_W'(root >> 1);
        end
        den_reg   <= (root == '0) ? ROOT_W'(1) : root;
        dzero_reg <= side_out.zero;
        dneg_reg  <= side_out.neg;
    end

    assign dctl_in.valid = prep_v_reg;
    assign dctl_in.zero  = dzero_reg;
    assign dctl_in.neg   = dneg_reg;

    hutv_div u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .num     (num_reg),
        .den     (den_reg),
        .ctl_in  (dctl_in),
        .quo     (quo),
        .ctl_out (dctl_out)
    );

    // sign, saturation and the zero-norm vector
    always_ff @(posedge clk)
    begin
        for (int a = 0; a < AXES; a++)
        begin
            if (dctl_out.zero)
            begin
                comp_reg[a] <= (a == AXES - 1) ? OUT_MAX : '0;
            end
            else if (dctl_out.neg[a])
            begin
                comp_reg[a] <= (quo[a] > Q_W'(32768)) ? OUT_MIN : OUT_W'(-quo[a]);
            end
            else
            begin
                comp_reg[a] <= (quo[a] > Q_W'(32767)) ? OUT_MAX : OUT_W'(quo[a]);
            end
        end
    end

    assign done   = done_reg;
    assign comp_x = comp_reg[0];
    assign comp_y = comp_reg[1];
    assign comp_z = comp_reg[2];
    assign comp_w = comp_reg[3];

    // a unit vector never comes out all zero
    a_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        done && comp_x == 16'sd0 && comp_y == 16'sd0 && comp_z == 16'sd0
        |-> comp_w != 16'sd0)
        else $error("result vector is all zero");

    // every item leaving the root stages reaches the divider through the numerator register
    a_div_valid: assert property (@(posedge clk) disable iff (!rst_n)
        side_out.valid |=> dctl_in.valid)
        else $error("request lost between root and divide stages");

    // a result strobe follows each valid divider output in the next cycle
    a_done: assert property (@(posedge clk) disable iff (!rst_n)
        dctl_out.valid |=> done)
        else $error("result strobe missing");

endmodule

`default_nettype wire
